/* sv/fgfr_pkg.sv */
// Package for the font glyph fetch and rotate block: constants, codes,
// controller states and the command/status structs. No dependencies.
package fgfr_pkg;

    localparam int GLYPH_BYTES  = 32;
    localparam int NARROW_BYTES = GLYPH_BYTES / 2;
    localparam int BUF_AW       = $clog2(GLYPH_BYTES);

    localparam logic [7:0]  LEAD_MIN    = 8'h80;
    localparam logic [7:0]  GB_OFFSET   = 8'hA0;
    localparam logic [14:0] GB_ROW_LEN  = 15'd94;
    localparam logic [31:0] GB_BIAS     = 32'd95;   // one row plus one column
    localparam logic [31:0] LOC_MAX     = 32'd267584;

    localparam logic [5:0]  LEN_NARROW  = 6'(NARROW_BYTES);
    localparam logic [5:0]  LEN_WIDE    = 6'(GLYPH_BYTES);

    localparam logic ACT_TEXT   = 1'b0;
    localparam logic ACT_GLYPH  = 1'b1;
    localparam logic KIND_FETCH = 1'b0;
    localparam logic KIND_GLYPH = 1'b1;

    localparam logic [0:0] CFG_WIDE_BASE   = 1'b0;
    localparam logic [0:0] CFG_NARROW_BASE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CALC,
        ST_ISSUE,
        ST_ZERO,
        ST_LOAD,
        ST_EMIT
    } fgfr_state_t;

    typedef struct packed {
        logic       buf_wr;
        logic       take_trail;
        logic       narrow_req;
        logic       lead_set;
        logic       calc;
        logic       wide_req;
        logic       bank_wr;
        logic       emit_rot;
        logic       emit_zero;
        logic       last;
        logic [1:0] blk;
        logic [3:0] idx;
    } fgfr_cmd_t;

    typedef struct packed {
        logic lead_pending;
        logic glyph_full;
        logic loc_over;
        logic run_wide;
        logic out_free;
    } fgfr_status_t;

endpackage

/* sv/fgfr_dp.sv */
// Datapath: config registers, lead byte, glyph buffer memory, transpose bank,
// location arithmetic and the output register. Depends on fgfr_pkg.
module fgfr_dp (
    input  logic                 clk,
    input  logic                 rst_n,
    input  fgfr_pkg::fgfr_cmd_t  cmd,
    output fgfr_pkg::fgfr_status_t status,
    input  logic                 cfg_we,
    input  logic [0:0]           cfg_index,
    input  logic [31:0]          cfg_data,
    input  logic [7:0]           value,
    input  logic                 out_stall,
    output logic                 out_valid,
    output logic                 kind,
    output logic [31:0]          address,
    output logic [5:0]           length,
    output logic [7:0]           data_byte,
    output logic                 last
);
    import fgfr_pkg::*;

    logic [31:0] wide_base_reg;
    logic [31:0] narrow_base_reg;
    logic        lead_pending_reg, lead_pending_next;
    logic [7:0]  lead_reg;
    logic [7:0]  trail_reg;
    logic [BUF_AW-1:0] fill_reg, fill_next;
    logic        wide_reg, wide_next;
    logic [31:0] loc_reg;

    logic [7:0]  glyph_mem [GLYPH_BYTES];
    logic [7:0]  rd_data_reg;
    logic [BUF_AW-1:0] rd_addr;
    logic [7:0]  bank_reg [8];

    logic        out_valid_reg, out_valid_next;
    logic        kind_reg;
    logic [31:0] address_reg;
    logic [5:0]  length_reg;
    logic [7:0]  data_reg;
    logic        last_reg;

    logic        out_load;
    logic        glyph_full;
    logic [7:0]  row, col;
    logic [14:0] row_prod;
    logic [31:0] loc_sum;
    logic [7:0]  rot_byte;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wide_base_reg   <= '0;
            narrow_base_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_WIDE_BASE:   wide_base_reg   <= cfg_data;
                CFG_NARROW_BASE: narrow_base_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    assign glyph_full = wide_reg ? (fill_reg == BUF_AW'(GLYPH_BYTES - 1))
                                 : (fill_reg == BUF_AW'(NARROW_BYTES - 1));

    always_comb
    begin
        lead_pending_next = lead_pending_reg;
        fill_next         = fill_reg;
        wide_next         = wide_reg;
        if (cmd.lead_set)
            lead_pending_next = 1'b1;
        if (cmd.take_trail)
            lead_pending_next = 1'b0;
        if (cmd.buf_wr)
            fill_next = glyph_full ? '0 : fill_reg + 1'b1;
        if (cmd.take_trail || cmd.narrow_req)
            fill_next = '0;
        if (cmd.narrow_req)
            wide_next = 1'b0;
        if (cmd.wide_req)
            wide_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lead_pending_reg <= 1'b0;
            lead_reg         <= '0;
            fill_reg         <= '0;
            wide_reg         <= 1'b0;
        end
        else
        begin
            lead_pending_reg <= lead_pending_next;
            fill_reg         <= fill_next;
            wide_reg         <= wide_next;
            if (cmd.lead_set)
                lead_reg <= value;
        end
    end

    // GB2312 location: (94*(row-1) + (col-1)) * 32, all with 32-bit wrap
    assign row      = lead_reg - GB_OFFSET;
    assign col      = trail_reg - GB_OFFSET;
    assign row_prod = 15'(row) * GB_ROW_LEN;
    assign loc_sum  = 32'(row_prod) + 32'(col) - GB_BIAS;

    always_ff @(posedge clk)
    begin
        if (cmd.take_trail)
            trail_reg <= value;
        if (cmd.calc)
            loc_reg <= {loc_sum[31-5:0], 5'b0};
    end

    // glyph buffer: one write port, one registered read port
    assign rd_addr = wide_reg ? {cmd.blk[1], cmd.idx[2:0], cmd.blk[0]}
                              : {1'b0, cmd.blk[0], cmd.idx[2:0]};

    always_ff @(posedge clk)
    begin
        if (cmd.buf_wr)
            glyph_mem[fill_reg] <= value;
        rd_data_reg <= glyph_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.bank_wr)
            bank_reg[3'(cmd.idx - 4'd1)] <= rd_data_reg;
    end

    // transposed byte k: bit j is bit 7-k of source byte j
    always_comb
    begin
        for (int j = 0; j < 8; j++)
            rot_byte[j] = bank_reg[j][3'd7 - cmd.idx[2:0]];
    end

    // output register
    assign out_load       = cmd.narrow_req || cmd.wide_req || cmd.emit_rot || cmd.emit_zero;
    assign out_valid_next = out_load ? 1'b1 : (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.narrow_req)
        begin
            kind_reg    <= KIND_FETCH;
            address_reg <= narrow_base_reg + {20'b0, value, 4'b0};
            length_reg  <= LEN_NARROW;
            data_reg    <= '0;
            last_reg    <= 1'b0;
        end
        else if (cmd.wide_req)
        begin
            kind_reg    <= KIND_FETCH;
            address_reg <= wide_base_reg + loc_reg;
            length_reg  <= LEN_WIDE;
            data_reg    <= '0;
            last_reg    <= 1'b0;
        end
        else if (cmd.emit_rot || cmd.emit_zero)
        begin
            kind_reg    <= KIND_GLYPH;
            address_reg <= '0;
            length_reg  <= '0;
            data_reg    <= cmd.emit_rot ? rot_byte : 8'd0;
            last_reg    <= cmd.last;
        end
    end

    assign status.lead_pending = lead_pending_reg;
    assign status.glyph_full   = glyph_full;
    assign status.loc_over     = loc_reg > LOC_MAX;
    assign status.run_wide     = wide_reg;
    assign status.out_free     = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign address   = address_reg;
    assign length    = length_reg;
    assign data_byte = data_reg;
    assign last      = last_reg;

    a_fill_narrow: assert property (@(posedge clk) disable iff (!rst_n)
        !wide_reg |-> fill_reg < BUF_AW'(NARROW_BYTES))
        else $error("fill count passed narrow glyph size");

    a_fetch_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && kind_reg == KIND_FETCH) |-> (!last_reg && data_reg == 8'd0))
        else $error("fetch request carries glyph payload");

endmodule

/* sv/fgfr_ctrl.sv */
// Controller state machine: input decode, run sequencing (load/transpose
// per 8x8 block), zero glyph and wide fetch issue. Depends on fgfr_pkg.
module fgfr_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic                   action,
    input  logic                   value_msb,
    input  logic                   end_of_text,
    input  fgfr_pkg::fgfr_status_t status,
    output logic                   in_ready,
    output fgfr_pkg::fgfr_cmd_t    cmd
);
    import fgfr_pkg::*;

    fgfr_state_t state_reg, state_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [1:0]  blk_reg, blk_next;
    logic [1:0]  last_blk;
    logic        accept;

    assign last_blk = status.run_wide ? 2'd3 : 2'd1;
    assign in_ready = (state_reg == ST_IDLE) && status.out_free;
    assign accept   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            blk_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            blk_reg   <= blk_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        blk_next   = blk_reg;
        cmd        = '0;
        cmd.blk    = blk_reg;
        cmd.idx    = cnt_reg[3:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (action == ACT_GLYPH)
                    begin
                        cmd.buf_wr = 1'b1;
                        if (status.glyph_full)
                        begin
                            state_next = ST_LOAD;
                            cnt_next   = '0;
                            blk_next   = '0;
                        end
                    end
                    else if (status.lead_pending)
                    begin
                        cmd.take_trail = 1'b1;
                        state_next     = ST_CALC;
                    end
                    else if (!value_msb)
                        cmd.narrow_req = 1'b1;
                    else if (!end_of_text)
                        cmd.lead_set = 1'b1;
                end
            end

            ST_CALC:
            begin
                cmd.calc   = 1'b1;
                state_next = ST_ISSUE;
            end

            ST_ISSUE:
            begin
                if (status.loc_over)
                begin
                    state_next = ST_ZERO;
                    cnt_next   = '0;
                end
                else if (status.out_free)
                begin
                    cmd.wide_req = 1'b1;
                    state_next   = ST_IDLE;
                end
            end

            ST_ZERO:
            begin
                if (status.out_free)
                begin
                    cmd.emit_zero = 1'b1;
                    cmd.last      = (cnt_reg == 5'(GLYPH_BYTES - 1));
                    cnt_next      = cnt_reg + 1'b1;
                    if (cmd.last)
                    begin
                        state_next = ST_IDLE;
                        cnt_next   = '0;
                    end
                end
            end

            ST_LOAD:
            begin
                // read issued at count c lands in the bank at count c+1
                cmd.bank_wr = (cnt_reg != 5'd0);
                if (cnt_reg == 5'd8)
                begin
                    state_next = ST_EMIT;
                    cnt_next   = '0;
                end
                else
                    cnt_next = cnt_reg + 1'b1;
            end

            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit_rot = 1'b1;
                    cmd.last     = (blk_reg == last_blk) && (cnt_reg == 5'd7);
                    cnt_next     = cnt_reg + 1'b1;
                    if (cnt_reg == 5'd7)
                    begin
                        cnt_next = '0;
                        if (blk_reg == last_blk)
                        begin
                            state_next = ST_IDLE;
                            blk_next   = '0;
                        end
                        else
                        begin
                            state_next = ST_LOAD;
                            blk_next   = blk_reg + 1'b1;
                        end
                    end
                end
            end

            default:
                state_next = ST_IDLE;
        endcase
    end

    a_load_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOAD) |-> cnt_reg <= 5'd8)
        else $error("bank load count overran");

    a_run_done: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_rot && cmd.last) |=> state_reg == ST_IDLE)
        else $error("controller did not return to idle after run");

endmodule

/* sv/font_glyph_fetch_and_rotate_core.sv */
// Top level of the font glyph fetch and rotate block: ports, config
// handshake, controller and datapath. Depends on fgfr_pkg, fgfr_ctrl, fgfr_dp.
//
// Text bytes (action 0) turn into font fetch requests: a byte below 0x80
// asks for 16 bytes at narrow_base + 16*code; a byte at or above 0x80 is
// held as a GB2312 lead byte (dropped if end_of_text is set) and the next
// text byte completes the code, asking for 32 bytes at wide_base +
// (94*(row-1)+(col-1))*32, or producing 32 zero glyph bytes directly when
// that location lies beyond the table. Glyph data bytes (action 1) are
// buffered; when a glyph is complete each 8x8 bit block is transposed and
// the glyph goes out as one run with last on its final byte. A single-byte
// text byte, a lead byte and a glyph data byte that does not complete a
// glyph each leave the controller in idle; a trail byte goes through the
// location multiply, then the compare and base add, before its fetch
// request or zero run. For each 8x8 block of a completed glyph, the single
// read port of the glyph buffer loads the eight source bytes of the block
// into a transpose bank, then one rotated byte leaves per cycle while the
// output is not stalled. Input is taken only while the controller is idle
// and the output register is free or draining; stall on the output side
// holds the sequencer. The config port is always ready; write it only
// while the block is idle.
module font_glyph_fetch_and_rotate_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        action,
    input  logic [7:0]  value,
    input  logic        end_of_text,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        kind,
    output logic [31:0] address,
    output logic [5:0]  length,
    output logic [7:0]  data_byte,
    output logic        last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import fgfr_pkg::*;

    fgfr_cmd_t    cmd;
    fgfr_status_t status;
    logic         in_ready;

    assign cfg_ready = 1'b1;
    assign in_stall  = !in_ready;

    fgfr_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .action      (action),
        .value_msb   (value[7]),
        .end_of_text (end_of_text),
        .status      (status),
        .in_ready    (in_ready),
        .cmd         (cmd)
    );

    fgfr_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .value     (value),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .kind      (kind),
        .address   (address),
        .length    (length),
        .data_byte (data_byte),
        .last      (last)
    );

endmodule
